// ===== hw/rtl/sced_pkg.sv =====
// ----------------------------------------------------------------------------
// sced_pkg
// Shared widths, codes and error arithmetic for the serpentine color
// error diffusion core.
// ----------------------------------------------------------------------------
package sced_pkg;

    localparam int LANES      = 3;
    localparam int PIX_W      = 8;
    localparam int ERR_W      = 14;
    localparam int ACC_W      = 16;
    localparam int PROD_W     = 20;
    localparam int WT_W       = 5;
    localparam int FRAC_BITS  = 4;
    localparam int ROUND_HALF = 8;
    localparam int WCFG_W     = 11;
    localparam int COL_OUT_W  = 10;
    localparam int CIDX_W     = 2;

    localparam int IN_FIELD_W  = LANES * PIX_W;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = LANES + COL_OUT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    typedef logic signed [ERR_W-1:0] t_err;
    typedef logic [CIDX_W-1:0]       t_cfg_idx;
    typedef logic signed [WT_W-1:0]  t_weight;

    localparam t_cfg_idx CFG_IMAGE_WIDTH = 2'd0;
    localparam t_cfg_idx CFG_THRESHOLD   = 2'd1;

    localparam logic [WCFG_W-1:0] RST_IMAGE_WIDTH = 11'd1024;
    localparam logic [PIX_W-1:0]  RST_THRESHOLD   = 8'd128;

    // full-scale level (255) in sixteenths
    localparam logic signed [ACC_W-1:0] FULL_SCALE = 16'sd4080;

    localparam t_weight W_AHEAD        = 5'sd7;
    localparam t_weight W_BELOW_BEHIND = 5'sd3;
    localparam t_weight W_BELOW        = 5'sd5;
    localparam t_weight W_BELOW_AHEAD  = 5'sd1;

    localparam logic signed [PROD_W-1:0] ERR_HI = PROD_W'(2 ** (ERR_W - 1) - 1);
    localparam logic signed [PROD_W-1:0] ERR_LO = PROD_W'(-(2 ** (ERR_W - 1)));

    function automatic t_err sat_err(input logic signed [PROD_W-1:0] x);
        t_err r;
        if (x > ERR_HI) begin
            r = ERR_W'(ERR_HI);
        end else if (x < ERR_LO) begin
            r = ERR_W'(ERR_LO);
        end else begin
            r = ERR_W'(x);
        end
        return r;
    endfunction

    // weighted share in sixteenths, rounded half up
    function automatic t_err share(input t_weight wt, input logic signed [ACC_W-1:0] e);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(wt) * PROD_W'(e) + PROD_W'(ROUND_HALF);
        return sat_err(p >>> FRAC_BITS);
    endfunction

endpackage

// ===== hw/rtl/serpentine_color_error_diffusion_core.sv =====
// ----------------------------------------------------------------------------
// serpentine_color_error_diffusion_core
// Serpentine Floyd-Steinberg halftoner for RGB pixels with a line store of
// next-row errors kept in signed sixteenths.
//
//   channel   dir  handshake            payload
//   cfg       in   i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//   s_axis    in   tvalid/tready        tdata rgb, tuser frame start
//   m_axis    out  tvalid/tready        tdata dots + column, tlast row end
//
// One pixel per clock unless m_axis stalls or the line store clears. Pixels
// are registered with the line store read, then diffused into the output
// register. Rate is set by the single-port-write line store, with the extra
// row-end write registered and forwarded. After reset s_axis_tready is low
// while the store clears; output stalls back up through the pixel register.
// ----------------------------------------------------------------------------
module serpentine_color_error_diffusion_core #(
    parameter int MAX_WIDTH = 1024,
    parameter int CHANNELS  = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  sced_pkg::t_cfg_idx              i_cfg_index,
    input  logic [sced_pkg::WCFG_W-1:0]     i_cfg_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sced_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // red, green, blue
    input  logic                            s_axis_tuser,   // frame_start
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sced_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // red_dot, green_dot,
                                                            // blue_dot, pixel_column
    output logic                            m_axis_tlast    // line_end
);
    import sced_pkg::*;

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (CW > WCFG_W) ? CW : WCFG_W;
    localparam int MEM_W = LANES * ERR_W;

    // configuration
    logic [WCFG_W-1:0] r_img_width;
    logic [PIX_W-1:0]  r_thresh;

    // row sequencing
    logic [AW-1:0] r_col, n_col;
    logic          r_rev, n_rev;
    logic          r_first, n_first;

    // line store clear
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    // pixel register
    logic                  r_s1_valid;
    logic [IN_FIELD_W-1:0] r_s1_pix;
    logic [AW-1:0]         r_s1_x;
    logic [AW-1:0]         r_s1_bh;
    logic                  r_s1_row_start;
    logic                  r_s1_last;
    logic                  r_s1_first;

    // line store
    logic [MEM_W-1:0] r_mem [MAX_WIDTH];
    logic [MEM_W-1:0] r_mem_q;
    logic             r_fwd_hit;
    logic [MEM_W-1:0] r_fwd_data;

    // diffusion state
    t_err r_ahead [LANES];
    t_err r_below [LANES];
    t_err r_bbp   [LANES];

    // deferred row-end write
    logic             r_dw_valid;
    logic [AW-1:0]    r_dw_addr;
    logic [MEM_W-1:0] r_dw_data;

    // output register
    logic                 r_ov;
    logic [LANES-1:0]     r_odots;
    logic [COL_OUT_W-1:0] r_ocol;
    logic                 r_olast;

    logic            accept, fire;
    logic [EW-1:0]   w_ext;
    logic [CW-1:0]   weff, wm1;
    logic [AW-1:0]   cc0, cc, x, bh;
    logic            rev0, rev, fr0, fr, wrap, last;
    logic [AW+COL_OUT_W-1:0] s1_x_ext;

    logic [MEM_W-1:0] rd_vec, bb_vec, nb_vec;
    logic             fw_last, fw_bh, fw_dw;

    logic             mem_we, dw_flush;
    logic [AW-1:0]    mem_waddr;
    logic [MEM_W-1:0] mem_wdata;

    logic [LANES-1:0] lane_dot;
    t_err             lane_s7 [LANES];
    t_err             lane_s1 [LANES];
    t_err             lane_nb [LANES];

    assign o_cfg_ready   = 1'b1;
    assign fire          = r_s1_valid && (!r_ov || m_axis_tready);
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || fire);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_width <= RST_IMAGE_WIDTH;
            r_thresh    <= RST_THRESHOLD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH: r_img_width <= i_cfg_data;
                CFG_THRESHOLD:   r_thresh    <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // column, direction and addresses of the incoming pixel
    always_comb begin
        w_ext = EW'(r_img_width);
        if (w_ext == '0) begin
            weff = CW'(1);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            weff = CW'(MAX_WIDTH);
        end else begin
            weff = CW'(w_ext);
        end
        wm1  = weff - CW'(1);

        cc0  = s_axis_tuser ? '0 : r_col;
        rev0 = s_axis_tuser ? 1'b0 : r_rev;
        fr0  = s_axis_tuser ? 1'b1 : r_first;
        wrap = (CW'(cc0) >= weff);
        cc   = wrap ? '0 : cc0;
        rev  = wrap ? !rev0 : rev0;
        fr   = wrap ? 1'b0 : fr0;

        x    = rev ? AW'(wm1 - CW'(cc)) : cc;
        bh   = rev ? x + AW'(1) : x - AW'(1);
        last = (CW'(cc) == wm1);

        n_col   = last ? '0 : cc + AW'(1);
        n_rev   = last ? !rev : rev;
        n_first = last ? 1'b0 : fr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_rev   <= 1'b0;
            r_first <= 1'b1;
        end else if (accept) begin
            r_col   <= n_col;
            r_rev   <= n_rev;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix       <= s_axis_tdata[IN_FIELD_W-1:0];
            r_s1_x         <= x;
            r_s1_bh        <= bh;
            r_s1_row_start <= (cc == '0);
            r_s1_last      <= last;
            r_s1_first     <= fr;
        end
    end

    // forward writes that land at or before the read edge
    assign fw_last = fire && r_s1_last && (x == r_s1_x);
    assign fw_bh   = fire && !r_s1_row_start && (x == r_s1_bh);
    assign fw_dw   = r_dw_valid && (x == r_dw_addr);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_hit <= fw_last || fw_bh || fw_dw;
            if (fw_last) begin
                r_fwd_data <= nb_vec;
            end else if (fw_bh) begin
                r_fwd_data <= bb_vec;
            end else begin
                r_fwd_data <= r_dw_data;
            end
        end
    end

    assign rd_vec = r_fwd_hit ? r_fwd_data : r_mem_q;

    // per-channel quantize and diffuse
    for (genvar c = 0; c < LANES; c++) begin : g_lane
        if (c < CHANNELS) begin : g_on
            logic [PIX_W-1:0]        v;
            logic [ACC_W-1:0]        v16, t16;
            t_err                    a_in, b_in, bb_in, st;
            logic signed [ACC_W-1:0] acc, e;
            t_err                    s3, s5;

            assign v     = ~r_s1_pix[c*PIX_W +: PIX_W];
            assign v16   = {{(ACC_W-PIX_W-FRAC_BITS){1'b0}}, v, {FRAC_BITS{1'b0}}};
            assign t16   = {{(ACC_W-PIX_W-FRAC_BITS){1'b0}}, r_thresh, {FRAC_BITS{1'b0}}};
            assign a_in  = r_s1_row_start ? '0 : r_ahead[c];
            assign b_in  = r_s1_row_start ? '0 : r_below[c];
            assign bb_in = r_s1_row_start ? '0 : r_bbp[c];
            assign st    = r_s1_first ? '0 : $signed(rd_vec[c*ERR_W +: ERR_W]);
            assign acc   = $signed(v16) + ACC_W'(a_in) + ACC_W'(st);
            assign lane_dot[c] = (acc >= $signed(t16));
            assign e     = lane_dot[c] ? acc - FULL_SCALE : acc;
            assign s3    = share(W_BELOW_BEHIND, e);
            assign s5    = share(W_BELOW, e);
            assign lane_s7[c] = share(W_AHEAD, e);
            assign lane_s1[c] = share(W_BELOW_AHEAD, e);
            assign lane_nb[c] = sat_err(PROD_W'(b_in) + PROD_W'(s5));
            assign bb_vec[c*ERR_W +: ERR_W] = sat_err(PROD_W'(bb_in) + PROD_W'(s3));
            assign nb_vec[c*ERR_W +: ERR_W] = lane_nb[c];

            always_ff @(posedge i_clk) begin
                if (fire) begin
                    r_ahead[c] <= lane_s7[c];
                    r_below[c] <= lane_s1[c];
                    r_bbp[c]   <= lane_nb[c];
                end
            end
        end else begin : g_off
            assign lane_dot[c] = 1'b1;
            assign lane_s7[c]  = '0;
            assign lane_s1[c]  = '0;
            assign lane_nb[c]  = '0;
            assign bb_vec[c*ERR_W +: ERR_W] = '0;
            assign nb_vec[c*ERR_W +: ERR_W] = '0;

            always_ff @(posedge i_clk) begin
                if (fire) begin
                    r_ahead[c] <= '0;
                    r_below[c] <= '0;
                    r_bbp[c]   <= '0;
                end
            end
        end
    end

    // line store write port: clear, then below-behind, then deferred row end
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_dw_addr;
        mem_wdata = r_dw_data;
        dw_flush  = 1'b0;
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (fire && !r_s1_row_start) begin
            mem_we    = 1'b1;
            mem_waddr = r_s1_bh;
            mem_wdata = bb_vec;
        end else if (r_dw_valid) begin
            mem_we    = 1'b1;
            dw_flush  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_q <= r_mem[x];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dw_valid <= 1'b0;
        end else if (fire && r_s1_last) begin
            r_dw_valid <= 1'b1;
        end else if (dw_flush) begin
            r_dw_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_s1_last) begin
            r_dw_addr <= r_s1_x;
            r_dw_data <= nb_vec;
        end
    end

    // output register
    assign s1_x_ext = {{COL_OUT_W{1'b0}}, r_s1_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (fire) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_odots <= ~lane_dot;
            r_ocol  <= s1_x_ext[COL_OUT_W-1:0];
            r_olast <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {{(OUT_DATA_W-OUT_FIELD_W){1'b0}}, r_ocol, r_odots};
    assign m_axis_tlast  = r_olast;

endmodule

// ===== tb/sv/serpentine_color_error_diffusion_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serpentine_color_error_diffusion_checker
// Watches the register, pixel and dot channels of the halftone core. Keeps
// its own serpentine Floyd-Steinberg model, with line store, carries and
// registers, predicts the dots of every accepted pixel and compares each
// dot transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module serpentine_color_error_diffusion_checker #(
    parameter int MAX_WIDTH = 1024,
    parameter int CHANNELS  = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  sced_pkg::t_cfg_idx              i_cfg_index,
    input  logic [sced_pkg::WCFG_W-1:0]     i_cfg_data,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [sced_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [sced_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                            i_m_tlast,
    output int                              o_fail_count,
    output int                              o_outstanding
);

    localparam int FULL_LEVEL      = 255 * 16;
    localparam int WT_AHEAD        = 7;
    localparam int WT_BELOW_BEHIND = 3;
    localparam int WT_BELOW        = 5;
    localparam int WT_BELOW_AHEAD  = 1;
    localparam int ERR_TOP         = 8191;
    localparam int ERR_BOTTOM      = -8192;

    typedef struct packed {
        logic                          red_dot;
        logic                          green_dot;
        logic                          blue_dot;
        logic [sced_pkg::COL_OUT_W-1:0] column;
        logic                          line_end;
    } t_dot_pixel;

    sced_pkg::t_err row_below_err [0:MAX_WIDTH-1][0:2];
    sced_pkg::t_err carry_ahead [0:2];
    sced_pkg::t_err carry_below [0:2];
    sced_pkg::t_err carry_below_behind [0:2];
    int              col_done;
    bit              reverse_dir;
    bit              top_row;
    logic [10:0]     cfg_width;
    logic [7:0]      cfg_thresh;

    t_dot_pixel pending_dots [$];
    t_dot_pixel want;
    int         fail_count = 0;
    int         pending_count = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = pending_count;

    function automatic sced_pkg::t_err clamp_err(input int v);
        int r;
        r = v;
        if (v > ERR_TOP) r = ERR_TOP;
        if (v < ERR_BOTTOM) r = ERR_BOTTOM;
        return r[sced_pkg::ERR_W-1:0];
    endfunction

    // weight/16 of the error, nearest, halves rounded up
    function automatic sced_pkg::t_err weighted_share(input int wt, input int err);
        int prod;
        prod = wt * err + 8;
        return clamp_err(prod >>> 4);
    endfunction

    function automatic void clear_carries();
        for (int c = 0; c < 3; c++) begin
            carry_ahead[c]        = '0;
            carry_below[c]        = '0;
            carry_below_behind[c] = '0;
        end
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < MAX_WIDTH; i++) begin
            for (int c = 0; c < 3; c++) begin
                row_below_err[i][c] = '0;
            end
        end
        clear_carries();
        col_done    = 0;
        reverse_dir = 1'b0;
        top_row     = 1'b1;
        cfg_width   = sced_pkg::RST_IMAGE_WIDTH;
        cfg_thresh  = sced_pkg::RST_THRESHOLD;
    endfunction

    function automatic t_dot_pixel halftone_pixel(input logic [23:0] rgb,
                                                  input logic frame_first);
        t_dot_pixel     res;
        int             w, x, behind, acc, err;
        sced_pkg::t_err nb;
        bit             behind_ok, row_last, dot;
        logic [2:0]     dots;
        w = int'(cfg_width);
        if (w == 0) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (frame_first) begin
            col_done    = 0;
            reverse_dir = 1'b0;
            top_row     = 1'b1;
            clear_carries();
        end
        // width dropped below the current position: close the row here
        if (col_done >= w) begin
            col_done    = 0;
            reverse_dir = !reverse_dir;
            top_row     = 1'b0;
            clear_carries();
        end
        x         = reverse_dir ? w - 1 - col_done : col_done;
        behind    = reverse_dir ? x + 1 : x - 1;
        behind_ok = (behind >= 0) && (behind < w);
        row_last  = (col_done == w - 1);
        dots      = '0;
        for (int c = 0; c < 3; c++) begin
            if (c < CHANNELS) begin
                acc = 16 * (255 - int'(rgb[8*c +: 8])) + int'(carry_ahead[c]);
                if (!top_row) acc += int'(row_below_err[x][c]);
                dot = (acc >= 16 * int'(cfg_thresh));
                err = dot ? acc - FULL_LEVEL : acc;
                if (behind_ok) begin
                    row_below_err[behind][c] = clamp_err(int'(carry_below_behind[c]) +
                        int'(weighted_share(WT_BELOW_BEHIND, err)));
                end
                nb = clamp_err(int'(carry_below[c]) +
                               int'(weighted_share(WT_BELOW, err)));
                if (row_last) row_below_err[x][c] = nb;
                carry_below_behind[c] = nb;
                carry_below[c]        = weighted_share(WT_BELOW_AHEAD, err);
                carry_ahead[c]        = weighted_share(WT_AHEAD, err);
                dots[c]               = !dot;
            end
        end
        res.red_dot   = dots[0];
        res.green_dot = dots[1];
        res.blue_dot  = dots[2];
        res.column    = x[sced_pkg::COL_OUT_W-1:0];
        res.line_end  = row_last;
        if (row_last) begin
            col_done    = 0;
            reverse_dir = !reverse_dir;
            top_row     = 1'b0;
            clear_carries();
        end else begin
            col_done++;
        end
        return res;
    endfunction

    function automatic void check_field(input string field, input int exp_val,
                                        input int got);
        if (exp_val != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, exp_val, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            pending_dots.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    sced_pkg::CFG_IMAGE_WIDTH: cfg_width = i_cfg_data;
                    sced_pkg::CFG_THRESHOLD:   cfg_thresh = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_dots.push_back(halftone_pixel(i_s_tdata[23:0], i_s_tuser));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_dots.size() == 0) begin
                    $error("dot transfer with no pixel pending, column %0d",
                           i_m_tdata[3 +: sced_pkg::COL_OUT_W]);
                    fail_count++;
                end else begin
                    want = pending_dots.pop_front();
                    check_field("red_dot", int'(want.red_dot), int'(i_m_tdata[0]));
                    check_field("green_dot", int'(want.green_dot), int'(i_m_tdata[1]));
                    check_field("blue_dot", int'(want.blue_dot), int'(i_m_tdata[2]));
                    check_field("pixel_column", int'(want.column),
                                int'(i_m_tdata[3 +: sced_pkg::COL_OUT_W]));
                    check_field("line_end", int'(want.line_end), int'(i_m_tlast));
                end
            end
        end
        pending_count = pending_dots.size();
    end

endmodule

// ===== tb/sv/tb_serpentine_color_error_diffusion_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_serpentine_color_error_diffusion_core
// Pixel stimulus for the serpentine halftone core: a directed run over
// register extremes, frame starts and mid-row width changes, then random
// frames of random or flat content over many width and threshold settings,
// with random stalls on both streams. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_serpentine_color_error_diffusion_core;

    localparam sced_pkg::t_cfg_idx CFG_SPARE_A = 2'd2;
    localparam sced_pkg::t_cfg_idx CFG_SPARE_B = 2'd3;
    localparam int RANDOM_PIXELS = 1300;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    sced_pkg::t_cfg_idx              i_cfg_index;
    logic [sced_pkg::WCFG_W-1:0]     i_cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [sced_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [sced_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    int fail_count;
    int outstanding;
    int idle_pct = 33;
    int pixel_count = 0;
    int frame_count = 0;
    int setting_count = 0;

    serpentine_color_error_diffusion_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    serpentine_color_error_diffusion_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tlast     (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("FAIL serpentine_color_error_diffusion_core");
        $finish;
    end

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                              input logic [7:0] b, input logic fs);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, g, r};
        s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        pixel_count++;
        if (fs) frame_count++;
    endtask

    // let every dot come out before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input sced_pkg::t_cfg_idx idx,
                             input logic [sced_pkg::WCFG_W-1:0] value, input bit hold);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (!hold) i_cfg_valid <= 1'b0;
        setting_count++;
    endtask

    function automatic logic [7:0] pick_level(input bit flat, input int gray);
        int v;
        if (flat) begin
            v = gray + $urandom_range(6) - 3;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            return v[7:0];
        end
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    initial begin
        int          phase;
        int          width, thr, nframes, rows, len, gray, random_start;
        bit          carry_on, flat;
        logic [7:0]  r, g, b;

        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = sced_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers, frame start mid row
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd128, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd127, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
        send_pixel(8'd1, 8'd254, 8'd200, 1'b0);
        // width shrinks below the current column
        drain();
        write_reg(sced_pkg::CFG_IMAGE_WIDTH, 11'd2, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd10, 8'd20, 8'd30, 1'b0);
        drain();
        write_reg(sced_pkg::CFG_THRESHOLD, {3'b101, 8'd0}, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd60, 8'd60, 8'd60, 1'b0);
        drain();
        write_reg(sced_pkg::CFG_THRESHOLD, 11'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd1, 8'd1, 8'd1, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        drain();
        write_reg(sced_pkg::CFG_IMAGE_WIDTH, 11'd0, 1'b0);
        send_pixel(8'd90, 8'd180, 8'd45, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b1);
        // unmapped indexes are ignored
        drain();
        write_reg(CFG_SPARE_A, 11'h7FF, 1'b1);
        write_reg(CFG_SPARE_B, 11'h7FF, 1'b0);
        send_pixel(8'd77, 8'd77, 8'd77, 1'b0);
        send_pixel(8'd200, 8'd30, 8'd100, 1'b0);
        drain();
        write_reg(sced_pkg::CFG_IMAGE_WIDTH, 11'd2047, 1'b1);
        write_reg(sced_pkg::CFG_THRESHOLD, 11'd128, 1'b0);
        send_pixel(8'd127, 8'd128, 8'd129, 1'b1);
        send_pixel(8'd64, 8'd192, 8'd32, 1'b0);
        send_pixel(8'd250, 8'd5, 8'd133, 1'b0);

        random_start = pixel_count;
        phase = 0;
        while (pixel_count - random_start < RANDOM_PIXELS) begin
            if (phase == 1) width = $urandom_range(513, 600);
            else if ($urandom_range(7) == 0) width = $urandom_range(17, 64);
            else width = $urandom_range(1, 16);
            case ($urandom_range(5))
                0: thr = 0;
                1: thr = 255;
                default: thr = $urandom_range(255);
            endcase
            drain();
            idle_pct = (phase == 2 || phase == 3) ? 0 : 33;
            write_reg(sced_pkg::CFG_IMAGE_WIDTH, width[10:0], 1'b1);
            write_reg(sced_pkg::CFG_THRESHOLD, {3'($urandom_range(7)), thr[7:0]}, 1'b0);
            nframes = (phase == 1) ? 1 : $urandom_range(1, 3);
            for (int f = 0; f < nframes; f++) begin
                rows = (phase == 1) ? 1 : $urandom_range(1, 6);
                len  = rows * width;
                if (phase == 1) len = width + 16;
                else if ($urandom_range(4) == 0) len = $urandom_range(1, len);
                carry_on = (f == 0) && (phase > 0) && ($urandom_range(4) == 0);
                flat     = ($urandom_range(2) == 0);
                gray     = $urandom_range(255);
                for (int p = 0; (p < len) && (pixel_count - random_start < RANDOM_PIXELS);
                     p++) begin
                    r = pick_level(flat, gray);
                    g = pick_level(flat, gray);
                    b = pick_level(flat, gray);
                    send_pixel(r, g, b, ((p == 0) && !carry_on) || ($urandom_range(99) == 0));
                end
            end
            phase++;
        end

        drain();
        repeat (20) @(negedge i_clk);
        $display("Run covered %0d pixels, %0d frame starts, %0d register writes over %0d phases",
                 pixel_count, frame_count, setting_count, phase);
        $display("Widths 0 to 2047 incl. mid-row shrink, thresholds 0 to 255, random stalls");
        if (fail_count == 0 && outstanding == 0) begin
            $display("PASS serpentine_color_error_diffusion_core");
        end else begin
            $display("FAIL serpentine_color_error_diffusion_core");
        end
        $finish;
    end

endmodule
